// ===== hw/rtl/mi4_pkg.sv =====
// Shared types, constants and index helpers for the 4x4 matrix inverse block.
// No dependencies; imported by mi4_div and matrix4_inverse_top.
package mi4_pkg;

    localparam int ElemW  = 15;   // input element, Q.8
    localparam int ResW   = 16;   // inverse element, Q8.8
    localparam int PosW   = 4;
    localparam int CofW   = 46;   // cofactor, Q.24
    localparam int ProdW  = 61;   // shared multiplier result
    localparam int DetW   = 62;   // determinant, Q.32
    localparam int DivW   = 62;   // divider operand width
    localparam int DivCntW = 6;
    localparam int FracSh = 16;

    localparam logic signed [ResW-1:0] ResMax = 16'sh7FFF;
    localparam logic signed [ResW-1:0] ResMin = 16'sh8000;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Column offset used by row t of permutation p, p in 0..5.
    function automatic logic [1:0] perm_col(input logic [2:0] p, input logic [1:0] t);
        logic [5:0] cols;
        case (p)
            3'd0:    cols = {2'd2, 2'd1, 2'd0};
            3'd1:    cols = {2'd1, 2'd2, 2'd0};
            3'd2:    cols = {2'd2, 2'd0, 2'd1};
            3'd3:    cols = {2'd0, 2'd2, 2'd1};
            3'd4:    cols = {2'd1, 2'd0, 2'd2};
            default: cols = {2'd0, 2'd1, 2'd2};
        endcase
        case (t)
            2'd0:    perm_col = cols[1:0];
            2'd1:    perm_col = cols[3:2];
            default: perm_col = cols[5:4];
        endcase
    endfunction

    // Odd permutations subtract their product.
    function automatic logic perm_neg(input logic [2:0] p);
        perm_neg = (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
    endfunction

    // Matrix index of minor entry (t, perm) with row i and column j removed.
    function automatic logic [3:0] minor_addr(input logic [1:0] i, input logic [1:0] j,
                                              input logic [2:0] p, input logic [1:0] t);
        logic [1:0] r;
        logic [1:0] c;
        logic [1:0] pc;
        pc = perm_col(p, t);
        r  = (t < i) ? t : t + 2'd1;
        c  = (pc < j) ? pc : pc + 2'd1;
        minor_addr = {r, c};
    endfunction

endpackage

// ===== hw/rtl/mi4_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mi4_pkg for widths and the status struct.
module mi4_div
    import mi4_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DivW-1:0]   num,
    input  logic [DivW-1:0]   den,
    output logic [DivW-1:0]   quot,
    output div_status_t       status
);

    logic [DivW-1:0]    num_reg, num_next;
    logic [DivW-1:0]    den_reg, den_next;
    logic [DivW-1:0]    rem_reg, rem_next;
    logic [DivW-1:0]    q_reg, q_next;
    logic [DivCntW-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DivW:0]      trial;
    logic               fits;

    // Shift in the next numerator bit and try the subtract
    assign trial = {rem_reg, num_reg[DivW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = DivCntW'(DivW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DivW'(trial - {1'b0, den_reg}) : trial[DivW-1:0];
            q_next   = {q_reg[DivW-2:0], fits};
            num_next = {num_reg[DivW-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign quot          = q_reg;
    assign status.busy   = busy_reg;
    assign status.done   = done_reg;

endmodule

// ===== hw/rtl/matrix4_inverse_top.sv =====
// 4x4 matrix inverse top level: element store, cofactor sequencer, output word.
// Depends on mi4_pkg and mi4_div.
//
// Sixteen elements are taken in row-major order, one a cycle. The block then
// stalls its input and works on one shared 46x15 multiplier: each cofactor is
// six triple products, each a fetch, two multiplies and an accumulate, plus a
// write of the signed cofactor; the four row-0 cofactors each also add a
// determinant term. If the determinant is zero one singular word follows.
// Otherwise each of the 16 inverse words comes from the bit-serial divider.
// The input stays stalled until the last word of a matrix has been issued, so
// a new matrix cannot be loaded before the previous one is through.
module matrix4_inverse_top
    import mi4_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [ElemW-1:0] element,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [ResW-1:0] inverse_element,
    output logic [PosW-1:0]        position,
    output logic                   singular,
    output logic                   last
);

    typedef enum logic [4:0] {
        S_LOAD   = 5'b00001,
        S_COF    = 5'b00010,
        S_DSTART = 5'b00100,
        S_DWAIT  = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic signed [ElemW-1:0] mat_reg [16];
    logic signed [CofW-1:0]  cst_reg [16];

    logic [3:0]  cnt_reg, cnt_next;
    logic [3:0]  cf_reg, cf_next;
    logic [2:0]  p_reg, p_next;
    logic [2:0]  ph_reg, ph_next;
    logic [3:0]  k_reg, k_next;

    logic signed [ElemW-1:0] rd_reg, rd_next;
    logic signed [ElemW-1:0] opa_reg, opa_next;
    logic signed [ProdW-1:0] prod_reg, prod_next;
    logic signed [CofW-1:0]  acc_reg, acc_next;
    logic signed [CofW-1:0]  cof_reg, cof_next;
    logic signed [DetW-1:0]  det_reg, det_next;
    logic signed [ResW-1:0]  res_reg, res_next;
    logic                    sing_reg, sing_next;

    logic                    ov_reg, ov_next;
    logic signed [ResW-1:0]  oe_reg, oe_next;
    logic [PosW-1:0]         op_reg, op_next;
    logic                    os_reg, os_next;
    logic                    ol_reg, ol_next;

    logic                    load_acc;
    logic                    cof_wr;
    logic [1:0]              ci, cj;
    logic [3:0]              rd_addr;
    logic signed [CofW-1:0]  mul_a;
    logic signed [ProdW-1:0] mul_y;
    logic signed [CofW-1:0]  cof_val;
    logic signed [CofW-1:0]  cst_rd;
    logic                    neg;
    logic [CofW-1:0]         cmag;
    logic [DivW-1:0]         dnum, dden;
    logic [DivW-1:0]         quot;
    logic                    dstart;
    div_status_t             div_st;

    assign ci = cf_reg[3:2];
    assign cj = cf_reg[1:0];

    // Pick the matrix word the sequencer needs next
    always_comb
    begin
        case (ph_reg)
            3'd0:    rd_addr = minor_addr(ci, cj, p_reg, 2'd1);
            3'd1:    rd_addr = minor_addr(ci, cj, p_reg, 2'd2);
            3'd4:    rd_addr = cf_reg;
            default: rd_addr = minor_addr(ci, cj, p_reg, 2'd0);
        endcase
    end

    // Shared multiplier
    always_comb
    begin
        case (ph_reg)
            3'd1:    mul_a = CofW'(opa_reg);
            3'd2:    mul_a = CofW'($signed(prod_reg[29:0]));
            default: mul_a = cof_reg;
        endcase
    end
    assign mul_y = ProdW'(mul_a * rd_reg);

    // Cofactor sign follows the checkerboard
    assign cof_val = (ci[0] ^ cj[0]) ? -acc_reg : acc_reg;

    // Divider operands from magnitudes
    assign cst_rd = cst_reg[k_reg];
    assign neg    = cst_rd[CofW-1] ^ det_reg[DetW-1];
    assign cmag   = cst_rd[CofW-1] ? CofW'(-cst_rd) : CofW'(cst_rd);
    assign dnum   = {cmag, {FracSh{1'b0}}};
    assign dden   = det_reg[DetW-1] ? DivW'(-det_reg) : DivW'(det_reg);

    mi4_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (dstart),
        .num    (dnum),
        .den    (dden),
        .quot   (quot),
        .status (div_st)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cf_next    = cf_reg;
        p_next     = p_reg;
        ph_next    = ph_reg;
        k_next     = k_reg;
        rd_next    = rd_reg;
        opa_next   = opa_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        cof_next   = cof_reg;
        det_next   = det_reg;
        res_next   = res_reg;
        sing_next  = sing_reg;
        ov_next    = ov_reg;
        oe_next    = oe_reg;
        op_next    = op_reg;
        os_next    = os_reg;
        ol_next    = ol_reg;
        load_acc   = 1'b0;
        cof_wr     = 1'b0;
        dstart     = 1'b0;

        // Drop the output word once taken
        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        case (state_reg)
            S_LOAD:
            begin
                load_acc = in_valid;
                if (in_valid)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == 4'd15)
                    begin
                        state_next = S_COF;
                        cf_next    = '0;
                        p_next     = '0;
                        ph_next    = 3'd7;
                        acc_next   = '0;
                        det_next   = '0;
                    end
                end
            end
            S_COF:
            begin
                case (ph_reg)
                    3'd0:
                    begin
                        opa_next = rd_reg;
                        rd_next  = mat_reg[rd_addr];
                        ph_next  = 3'd1;
                    end
                    3'd1:
                    begin
                        prod_next = mul_y;
                        rd_next   = mat_reg[rd_addr];
                        ph_next   = 3'd2;
                    end
                    3'd2:
                    begin
                        prod_next = mul_y;
                        ph_next   = 3'd3;
                    end
                    3'd3:
                    begin
                        acc_next = perm_neg(p_reg)
                                   ? acc_reg - CofW'($signed(prod_reg[44:0]))
                                   : acc_reg + CofW'($signed(prod_reg[44:0]));
                        if (p_reg == 3'd5)
                            ph_next = 3'd4;
                        else
                        begin
                            p_next  = p_reg + 1'b1;
                            ph_next = 3'd6;
                        end
                    end
                    3'd4:
                    begin
                        cof_wr   = 1'b1;
                        cof_next = cof_val;
                        rd_next  = mat_reg[rd_addr];
                        acc_next = '0;
                        p_next   = '0;
                        if (ci == 2'd0)
                            ph_next = 3'd5;
                        else if (cf_reg == 4'd15)
                        begin
                            if (det_reg == '0)
                            begin
                                sing_next  = 1'b1;
                                res_next   = '0;
                                k_next     = '0;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                sing_next  = 1'b0;
                                k_next     = '0;
                                state_next = S_DSTART;
                            end
                        end
                        else
                        begin
                            cf_next = cf_reg + 1'b1;
                            ph_next = 3'd7;
                        end
                    end
                    3'd5:
                    begin
                        prod_next = mul_y;
                        ph_next   = 3'd6;
                        p_next    = 3'd6;
                    end
                    3'd6:
                    begin
                        // Either accumulate the determinant term or fetch a new product
                        if (p_reg == 3'd6)
                        begin
                            det_next = det_reg + DetW'(prod_reg);
                            cf_next  = cf_reg + 1'b1;
                            p_next   = '0;
                            ph_next  = 3'd7;
                        end
                        else
                        begin
                            rd_next = mat_reg[rd_addr];
                            ph_next = 3'd0;
                        end
                    end
                    default:
                    begin
                        rd_next = mat_reg[rd_addr];
                        ph_next = 3'd0;
                    end
                endcase
            end
            S_DSTART:
            begin
                dstart     = 1'b1;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_st.done)
                begin
                    if (!neg)
                        res_next = (quot > DivW'(32767)) ? ResMax : ResW'(quot);
                    else
                        res_next = (quot > DivW'(32768)) ? ResMin : ResW'(-quot);
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    oe_next = res_reg;
                    op_next = k_reg;
                    os_next = sing_reg;
                    ol_next = sing_reg || (k_reg == 4'd15);
                    if (sing_reg || (k_reg == 4'd15))
                        state_next = S_LOAD;
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_DSTART;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            cf_reg    <= '0;
            p_reg     <= '0;
            ph_reg    <= '0;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
            det_reg   <= '0;
            sing_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cf_reg    <= cf_next;
            p_reg     <= p_next;
            ph_reg    <= ph_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
            det_reg   <= det_next;
            sing_reg  <= sing_next;
        end
    end

    // Datapath and stores
    always_ff @(posedge clk)
    begin
        rd_reg   <= rd_next;
        opa_reg  <= opa_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        cof_reg  <= cof_next;
        res_reg  <= res_next;
        oe_reg   <= oe_next;
        op_reg   <= op_next;
        os_reg   <= os_next;
        ol_reg   <= ol_next;
        if (load_acc)
            mat_reg[cnt_reg] <= element;
        if (cof_wr)
            cst_reg[{cj, ci}] <= cof_val;
    end

    assign in_stall        = (state_reg != S_LOAD);
    assign out_valid       = ov_reg;
    assign inverse_element = oe_reg;
    assign position        = op_reg;
    assign singular        = os_reg;
    assign last            = ol_reg;

    // Singular word carries fixed fields
    a_sing_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && singular) |-> (last && inverse_element == '0 && position == '0))
        else $error("singular word with bad fields");

    // Divider finishes only while awaited
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == S_DWAIT))
        else $error("divider done outside wait state");

    // Determinant term only for row-0 cofactors
    a_det_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COF && ph_reg == 3'd5) |-> (ci == 2'd0))
        else $error("determinant term outside row 0");

endmodule
